// ----- rtl/pireg_pkg.sv -----
// shared constants, types and saturation helpers for the pi regulator
`timescale 1ns / 1ps

package pireg_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int GAIN_W     = 31;
  localparam int DT_W       = 16;
  localparam int MUL_A_W    = 48;
  localparam int MUL_B_W    = 32;
  localparam int PROD_W     = MUL_A_W + 1 + MUL_B_W;
  localparam int DIV_W      = 63;
  localparam int CNT_W      = 6;
  localparam int WIDE_W     = 66;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_KP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KI    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_G     = 2'd3;

  localparam logic REQ_UPDATE   = 1'b0;
  localparam logic REQ_RESIDUAL = 1'b1;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  typedef enum logic [2:0] {
    OP_ED = 3'd0,
    OP_KE = 3'd1,
    OP_KC = 3'd2,
    OP_KI = 3'd3,
    OP_GR = 3'd4,
    OP_PD = 3'd5
  } op_e;

  // saturate a wide signed value to the data width
  function automatic logic signed [DATA_WIDTH-1:0] sat_dw(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = signed'((WIDE_W'(1) << (DATA_WIDTH - 1)) - WIDE_W'(1));
    lo = -hi - WIDE_W'(1);
    if (x > hi) return DATA_WIDTH'(hi);
    if (x < lo) return DATA_WIDTH'(lo);
    return DATA_WIDTH'(x);
  endfunction

  // clamp to plus or minus the integral bound
  function automatic logic signed [DATA_WIDTH-1:0] clamp_bound(
    input logic signed [DATA_WIDTH-1:0] x, input logic [GAIN_W-1:0] b);
    logic signed [DATA_WIDTH:0] xs;
    logic signed [DATA_WIDTH:0] bp;
    logic signed [DATA_WIDTH:0] bn;
    xs = (DATA_WIDTH+1)'(x);
    bp = signed'({2'b00, b});
    bn = -bp;
    if (xs < bn) return DATA_WIDTH'(bn);
    if (xs > bp) return DATA_WIDTH'(bp);
    return x;
  endfunction

endpackage

// ----- rtl/pi_regulator_with_anti_windup.sv -----
// pi regulator axis with conditional integration and back-calculation
//
//  channel | direction | handshake             | payload
//  cfg     | in        | cfg_we_i              | cfg_index_i, cfg_data_i
//  in      | in        | in_valid_i/in_stall_o | req_type_i and six value fields
//  out     | out       | out_valid_o/out_stall_i | effort, integral, status
//
// one transaction at a time; products come from a bit-serial shift-add multiplier
// and the division from a restoring divider (63 quotient bits, one per cycle).
// an update takes 4 products, a residual 2 products and a division; rejected
// items and residuals with zero ki skip the arithmetic and go straight to done.
// while the output is stalled the result is held.
// reset clears the integral, the gains and the control state.
// in_stall_o is high from acceptance until the result transaction completes.
`timescale 1ns / 1ps

module pi_regulator_with_anti_windup import pireg_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [GAIN_W-1:0]            cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         req_type_i,
  input  logic signed [DATA_WIDTH-1:0] error_value_i,
  input  logic signed [DATA_WIDTH-1:0] feedforward_value_i,
  input  logic [GAIN_W-1:0]            upper_total_limit_i,
  input  logic [GAIN_W-1:0]            lower_total_limit_i,
  input  logic [DT_W-1:0]              step_time_i,
  input  logic signed [DATA_WIDTH-1:0] residual_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] effort_value_o,
  output logic signed [DATA_WIDTH-1:0] integral_value_o,
  output logic                         status_code_o
);

  state_e state_q, state_d;
  op_e    op_q, op_d;

  logic [GAIN_W-1:0] kp_q, ki_q, bound_q, g_q;

  logic                         typ_q, typ_d;
  logic signed [DATA_WIDTH-1:0] err_q, err_d, ff_q, ff_d;
  logic [GAIN_W-1:0]            up_q, up_d, low_q, low_d;
  logic [DT_W-1:0]              dt_q, dt_d;

  logic signed [DATA_WIDTH-1:0] intg_q, intg_d, cand_q, cand_d, pterm_q, pterm_d;
  logic signed [DATA_WIDTH-1:0] effort_q, effort_d;
  logic                         status_q, status_d;

  logic signed [MUL_A_W-1:0] mul_a_q, mul_a_d;
  logic signed [MUL_A_W:0]   mul_hi_q, mul_hi_d;
  logic [MUL_B_W-1:0]        mul_lo_q, mul_lo_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;

  logic [DIV_W-1:0]  dvd_q, dvd_d;
  logic [GAIN_W-1:0] rem_q, rem_d;
  logic              neg_q, neg_d;

  // multiplier datapath
  logic signed [MUL_A_W:0]   msum;
  logic signed [PROD_W-1:0]  prod;
  logic signed [DATA_WIDTH-1:0] mres;
  logic signed [63:0]        num;
  logic [63:0]               mag;

  // divider datapath
  logic [GAIN_W:0]   trial;
  logic              ge;

  // misc results
  logic signed [DATA_WIDTH-1:0] fb, total, eff, inew;
  logic signed [DATA_WIDTH+1:0] eff34, lo_fb, hi_fb, ec;
  logic signed [WIDE_W-1:0]     qw;
  logic                         wind;
  logic                         bad;

  assign msum = mul_hi_q + (mul_lo_q[0] ? {mul_a_q[MUL_A_W-1], mul_a_q} : '0);
  assign prod = signed'({mul_hi_q, mul_lo_q});
  assign mres = sat_dw(WIDE_W'(signed'(prod[PROD_W-1:FRAC_BITS])));
  assign num  = signed'(prod[63:0]);
  assign mag  = num[63] ? 64'(-num) : 64'(num);
  assign trial = {rem_q, dvd_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, ki_q};

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= '0;
      ki_q    <= '0;
      bound_q <= '0;
      g_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_KP:    kp_q    <= cfg_data_i;
        CFG_KI:    ki_q    <= cfg_data_i;
        CFG_BOUND: bound_q <= cfg_data_i;
        CFG_G:     g_q     <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // sequencer and serial arithmetic
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    typ_d    = typ_q;
    err_d    = err_q;
    ff_d     = ff_q;
    up_d     = up_q;
    low_d    = low_q;
    dt_d     = dt_q;
    intg_d   = intg_q;
    cand_d   = cand_q;
    pterm_d  = pterm_q;
    effort_d = effort_q;
    status_d = status_q;
    mul_a_d  = mul_a_q;
    mul_hi_d = mul_hi_q;
    mul_lo_d = mul_lo_q;
    cnt_d    = cnt_q;
    dvd_d    = dvd_q;
    rem_d    = rem_q;
    neg_d    = neg_q;
    fb       = '0;
    total    = '0;
    eff      = '0;
    inew     = '0;
    eff34    = '0;
    lo_fb    = '0;
    hi_fb    = '0;
    ec       = '0;
    qw       = '0;
    wind     = 1'b0;
    bad      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          typ_d    = req_type_i;
          err_d    = error_value_i;
          ff_d     = feedforward_value_i;
          up_d     = upper_total_limit_i;
          low_d    = lower_total_limit_i;
          dt_d     = step_time_i;
          effort_d = '0;
          status_d = STATUS_OK;
          mul_hi_d = '0;
          cnt_d    = '0;
          if (req_type_i == REQ_UPDATE) begin
            bad = (step_time_i == '0) || (upper_total_limit_i == '0) ||
                  (lower_total_limit_i == '0);
            if (bad) begin
              status_d = STATUS_REJECT;
              state_d  = ST_DONE;
            end else begin
              op_d     = OP_ED;
              mul_a_d  = MUL_A_W'(error_value_i);
              mul_lo_d = MUL_B_W'(step_time_i);
              state_d  = ST_MUL;
            end
          end else begin
            if (step_time_i == '0) begin
              status_d = STATUS_REJECT;
              state_d  = ST_DONE;
            end else if (ki_q == '0) begin
              state_d = ST_DONE;
            end else begin
              op_d     = OP_GR;
              mul_a_d  = MUL_A_W'(residual_value_i);
              mul_lo_d = MUL_B_W'(g_q);
              state_d  = ST_MUL;
            end
          end
        end
      end

      ST_MUL: begin
        if (cnt_q != CNT_W'(MUL_B_W)) begin
          // one shift-add step per cycle
          mul_hi_d = msum >>> 1;
          mul_lo_d = {msum[0], mul_lo_q[MUL_B_W-1:1]};
          cnt_d    = cnt_q + CNT_W'(1);
        end else begin
          mul_hi_d = '0;
          cnt_d    = '0;
          unique case (op_q)
            OP_ED: begin
              cand_d   = clamp_bound(sat_dw(WIDE_W'(intg_q) + WIDE_W'(mres)), bound_q);
              op_d     = OP_KE;
              mul_a_d  = MUL_A_W'(err_q);
              mul_lo_d = MUL_B_W'(kp_q);
            end
            OP_KE: begin
              pterm_d  = mres;
              op_d     = OP_KC;
              mul_a_d  = MUL_A_W'(cand_q);
              mul_lo_d = MUL_B_W'(ki_q);
            end
            OP_KC: begin
              // conditional integration
              fb    = sat_dw(WIDE_W'(pterm_q) + WIDE_W'(mres));
              total = sat_dw(WIDE_W'(ff_q) + WIDE_W'(fb));
              wind  = ((WIDE_W'(total) > signed'(WIDE_W'(up_q))) && (err_q > 0)) ||
                      ((WIDE_W'(total) < -signed'(WIDE_W'(low_q))) && (err_q < 0));
              inew  = wind ? intg_q : cand_q;
              intg_d   = inew;
              op_d     = OP_KI;
              mul_a_d  = MUL_A_W'(inew);
              mul_lo_d = MUL_B_W'(ki_q);
            end
            OP_KI: begin
              // clamp so feedforward plus effort stays in limits
              eff   = sat_dw(WIDE_W'(pterm_q) + WIDE_W'(mres));
              eff34 = (DATA_WIDTH+2)'(eff);
              lo_fb = -signed'((DATA_WIDTH+2)'(low_q)) - (DATA_WIDTH+2)'(ff_q);
              hi_fb = signed'((DATA_WIDTH+2)'(up_q)) - (DATA_WIDTH+2)'(ff_q);
              if (eff34 < lo_fb) ec = lo_fb;
              else if (eff34 > hi_fb) ec = hi_fb;
              else ec = eff34;
              effort_d = sat_dw(WIDE_W'(ec));
              state_d  = ST_DONE;
            end
            OP_GR: begin
              op_d     = OP_PD;
              mul_a_d  = signed'(prod[MUL_A_W+FRAC_BITS-1:FRAC_BITS]);
              mul_lo_d = MUL_B_W'(dt_q);
            end
            OP_PD: begin
              neg_d   = num[63];
              dvd_d   = mag[DIV_W-1:0];
              rem_d   = '0;
              state_d = ST_DIV;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end

      ST_DIV: begin
        if (cnt_q != CNT_W'(DIV_W)) begin
          // one restoring quotient bit per cycle
          rem_d = ge ? GAIN_W'(trial - {1'b0, ki_q}) : trial[GAIN_W-1:0];
          dvd_d = {dvd_q[DIV_W-2:0], ge};
          cnt_d = cnt_q + CNT_W'(1);
        end else begin
          cnt_d   = '0;
          qw      = WIDE_W'(dvd_q);
          if (neg_q) qw = -qw;
          intg_d  = clamp_bound(sat_dw(WIDE_W'(intg_q) - qw), bound_q);
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_ED;
      cnt_q   <= '0;
      intg_q  <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
      intg_q  <= intg_d;
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk_i) begin
    typ_q    <= typ_d;
    err_q    <= err_d;
    ff_q     <= ff_d;
    up_q     <= up_d;
    low_q    <= low_d;
    dt_q     <= dt_d;
    cand_q   <= cand_d;
    pterm_q  <= pterm_d;
    effort_q <= effort_d;
    status_q <= status_d;
    mul_a_q  <= mul_a_d;
    mul_hi_q <= mul_hi_d;
    mul_lo_q <= mul_lo_d;
    dvd_q    <= dvd_d;
    rem_q    <= rem_d;
    neg_q    <= neg_d;
  end

  // ports
  assign in_stall_o       = state_q != ST_IDLE;
  assign out_valid_o      = state_q == ST_DONE;
  assign effort_value_o   = effort_q;
  assign integral_value_o = intg_q;
  assign status_code_o    = status_q;

  // checks
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("sequencer state not one-hot");

  a_reject_zero_effort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_code_o == STATUS_REJECT) |-> effort_value_o == '0)
    else $error("rejected transaction with nonzero effort");

  a_residual_zero_effort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && typ_q == REQ_RESIDUAL) |-> effort_value_o == '0)
    else $error("residual transaction with nonzero effort");

  a_reject_keeps_integral: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i && req_type_i == REQ_RESIDUAL &&
     step_time_i == '0) |=> $stable(intg_q))
    else $error("rejected residual changed the integral");

endmodule
